// File: design/phase_current_window_averager_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the phase current window averager
// Concurrent checks clocked by clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PHASE_CURRENT_WINDOW_AVERAGER_CORE_ASSERT_SVH
`define PHASE_CURRENT_WINDOW_AVERAGER_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define PCWA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PCWA_ASSERT_IMP(label, ante, cons, msg)
`define PCWA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: design/pcwa_pkg.sv
// ----------------------------------------------------------------------------
// pcwa_pkg
// Shared widths, register indexes, command and status types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcwa_pkg;

  localparam int SAMPLE_W    = 12;
  localparam int PATTERN_W   = 8;
  localparam int DUTY_W      = 16;
  localparam int VALUE_W     = 28;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int MEAN_W      = 12;
  localparam int PROD_W      = 28;
  localparam int DVS_W       = 16;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OFFSET_CODE  = 2'd0,
    REG_PATTERN_A    = 2'd1,
    REG_PATTERN_B    = 2'd2,
    REG_CARRIER_BASE = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EVAL,
    OP_MEAN_START,
    OP_MUL,
    OP_SCALE_START,
    OP_STOP_DONE,
    OP_BURST_ACC,
    OP_BURST_START,
    OP_BURST_DONE,
    OP_OUT_LOAD
  } op_t;

  typedef enum logic [2:0] {
    KIND_FILL,
    KIND_STOP_ACC,
    KIND_STOP_REPORT,
    KIND_CLOSE,
    KIND_IDLE
  } kind_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_done;
    logic  burst_full;
  } status_t;

endpackage

// File: design/phase_current_window_averager_core.sv
// ----------------------------------------------------------------------------
// phase_current_window_averager_core
// Conduction-window current averager for one motor phase.
// ----------------------------------------------------------------------------
// Each input word carries one ADC sample of the phase shunt, the active
// commutation pattern and the PWM duty, and yields exactly one result word.
// While the pattern matches pattern_a or pattern_b, the distance of the sample
// from offset_code is summed into a conduction window. When the pattern leaves,
// the window mean is scaled by duty / carrier_base and added to a burst, and
// every BURST_COUNT windows the burst mean is reported. A window that reaches
// WINDOW_LIMIT samples marks the motor stopped and feeds a slow average that is
// reported every STOPPED_LIMIT such samples; IDLE_LIMIT samples with no window
// open report zero. The block handles one word at a time; an ordinary sample
// needs no division. Every division runs through one shared restoring divider
// that produces one quotient bit per cycle over W = 28 + log2(BURST_COUNT)
// bits (31 by default), and the sequencer waits on it: a window close runs a
// mean and a scale division, a close that completes a burst adds a burst
// division, and a stopped-average report runs a mean and a scale division.
// A finished result sits in the output register, so the next word is accepted
// while it waits to be taken; it only stalls the sequencer when a second
// result is ready before the first has left. Configuration writes take effect
// at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phase_current_window_averager_core #(
  parameter int WINDOW_LIMIT  = 2000,
  parameter int STOPPED_LIMIT = 1000,
  parameter int BURST_COUNT   = 8,
  parameter int IDLE_LIMIT    = 2000
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port.
  input  logic                                wr_en,
  input  logic [pcwa_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [pcwa_pkg::CFG_DATA_W-1:0]     wr_data,
  // Input words.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pcwa_pkg::SAMPLE_W-1:0]       sample,
  input  logic [pcwa_pkg::PATTERN_W-1:0]      pattern,
  input  logic [pcwa_pkg::DUTY_W-1:0]         duty,
  // Result words.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                result_written,
  output logic [pcwa_pkg::VALUE_W-1:0]        current_value,
  output logic                                rotor_halted
);

  // The sequencer issues one datapath command per cycle and watches the
  // divider and accumulator status that comes back.
  pcwa_pkg::cmd_t    cmd;
  pcwa_pkg::status_t status;

  pcwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds configuration, all accumulators, the duty multiplier,
  // the shared divider and the output payload register.
  pcwa_datapath #(
    .WINDOW_LIMIT  (WINDOW_LIMIT),
    .STOPPED_LIMIT (STOPPED_LIMIT),
    .BURST_COUNT   (BURST_COUNT),
    .IDLE_LIMIT    (IDLE_LIMIT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .sample         (sample),
    .pattern        (pattern),
    .duty           (duty),
    .cmd            (cmd),
    .status         (status),
    .result_written (result_written),
    .current_value  (current_value),
    .rotor_halted   (rotor_halted)
  );

endmodule

// File: design/pcwa_div.sv
// ----------------------------------------------------------------------------
// pcwa_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcwa_div #(
  parameter int DVD_W = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [pcwa_pkg::DVS_W-1:0]   divisor,
  output logic [DVD_W-1:0]             quotient,
  output logic                         done
);

  localparam int DVS_W = pcwa_pkg::DVS_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_next;
  logic [DVD_W-1:0] quo_next;

  always_comb begin
    trial    = {rem, quo[DVD_W-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_next = {quo[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

// File: design/pcwa_datapath.sv
// ----------------------------------------------------------------------------
// pcwa_datapath
// Configuration, window, burst and stopped accumulators, multiplier, divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcwa_datapath #(
  parameter int WINDOW_LIMIT  = 2000,
  parameter int STOPPED_LIMIT = 1000,
  parameter int BURST_COUNT   = 8,
  parameter int IDLE_LIMIT    = 2000
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pcwa_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [pcwa_pkg::CFG_DATA_W-1:0]     wr_data,
  input  logic [pcwa_pkg::SAMPLE_W-1:0]       sample,
  input  logic [pcwa_pkg::PATTERN_W-1:0]      pattern,
  input  logic [pcwa_pkg::DUTY_W-1:0]         duty,
  input  pcwa_pkg::cmd_t                      cmd,
  output pcwa_pkg::status_t                   status,
  output logic                                result_written,
  output logic [pcwa_pkg::VALUE_W-1:0]        current_value,
  output logic                                rotor_halted
);

  localparam int SAMPLE_W = pcwa_pkg::SAMPLE_W;
  localparam int VALUE_W  = pcwa_pkg::VALUE_W;
  localparam int MEAN_W   = pcwa_pkg::MEAN_W;
  localparam int PROD_W   = pcwa_pkg::PROD_W;
  localparam int DVS_W    = pcwa_pkg::DVS_W;
  localparam int WSUM_W   = $clog2(WINDOW_LIMIT * pcwa_pkg::SAMPLE_MAX + 1);
  localparam int WCNT_W   = $clog2(WINDOW_LIMIT + 1);
  localparam int SSUM_W   = $clog2(STOPPED_LIMIT * pcwa_pkg::SAMPLE_MAX + 1);
  localparam int SCNT_W   = $clog2(STOPPED_LIMIT + 1);
  localparam int BSUM_W   = VALUE_W + $clog2(BURST_COUNT);
  localparam int BCNT_W   = $clog2(BURST_COUNT + 1);
  localparam int ICNT_W   = $clog2(IDLE_LIMIT + 1);

  // Configuration registers.
  logic [SAMPLE_W-1:0]            offset_code;
  logic [pcwa_pkg::PATTERN_W-1:0] pattern_a;
  logic [pcwa_pkg::PATTERN_W-1:0] pattern_b;
  logic [pcwa_pkg::DUTY_W-1:0]    carrier_base;

  // Accumulator state.
  logic [WSUM_W-1:0]     window_sum;
  logic [WCNT_W-1:0]     window_count;
  logic [BSUM_W-1:0]     burst_sum;
  logic [BCNT_W-1:0]     burst_count;
  logic [SSUM_W-1:0]     stopped_sum;
  logic [SCNT_W-1:0]     stopped_count;
  logic [ICNT_W-1:0]     idle_count;
  logic                  in_window;
  logic                  stopped_flag;
  pcwa_pkg::kind_t       kind;

  // Latched word and intermediate results.
  logic [SAMPLE_W-1:0]            s_reg;
  logic [pcwa_pkg::PATTERN_W-1:0] p_reg;
  logic [pcwa_pkg::DUTY_W-1:0]    d_reg;
  logic [PROD_W-1:0]              prod;
  logic                           res_written;
  logic [VALUE_W-1:0]             res_value;

  // Divider interface.
  logic              div_start;
  logic [BSUM_W-1:0] div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic [BSUM_W-1:0] div_quotient;
  logic              div_done;

  logic                match;
  logic [SAMPLE_W-1:0] diff;
  logic [ICNT_W-1:0]   idle_next;
  logic [MEAN_W-1:0]   mean_q;

  always_comb begin
    match     = (p_reg == pattern_a) || (p_reg == pattern_b);
    diff      = (s_reg > offset_code) ? (s_reg - offset_code) : (offset_code - s_reg);
    idle_next = (idle_count < ICNT_W'(IDLE_LIMIT)) ? (idle_count + 1'b1) : idle_count;
    mean_q    = div_quotient[MEAN_W-1:0];
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DVS_W'(1);
    case (cmd.op)
      pcwa_pkg::OP_MEAN_START: begin
        div_start = 1'b1;
        if (kind == pcwa_pkg::KIND_STOP_REPORT) begin
          div_dividend = BSUM_W'(stopped_sum);
          div_divisor  = DVS_W'(stopped_count);
        end else if (window_count != '0) begin
          div_dividend = BSUM_W'(window_sum);
          div_divisor  = DVS_W'(window_count);
        end
      end
      pcwa_pkg::OP_SCALE_START: begin
        div_start    = 1'b1;
        div_dividend = BSUM_W'(prod);
        if (carrier_base != '0) begin
          div_divisor = carrier_base;
        end
      end
      pcwa_pkg::OP_BURST_START: begin
        div_start    = 1'b1;
        div_dividend = burst_sum;
        div_divisor  = DVS_W'(burst_count);
      end
      default: begin
      end
    endcase
  end

  pcwa_div #(
    .DVD_W (BSUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_code   <= '0;
      pattern_a     <= '0;
      pattern_b     <= 8'd1;
      carrier_base  <= 16'd1;
      window_sum    <= '0;
      window_count  <= '0;
      burst_sum     <= '0;
      burst_count   <= '0;
      stopped_sum   <= '0;
      stopped_count <= '0;
      idle_count    <= '0;
      in_window     <= 1'b0;
      stopped_flag  <= 1'b0;
      kind          <= pcwa_pkg::KIND_IDLE;
    end else begin
      if (wr_en) begin
        case (pcwa_pkg::reg_index_t'(wr_index))
          pcwa_pkg::REG_OFFSET_CODE:  offset_code  <= wr_data[SAMPLE_W-1:0];
          pcwa_pkg::REG_PATTERN_A:    pattern_a    <= wr_data[pcwa_pkg::PATTERN_W-1:0];
          pcwa_pkg::REG_PATTERN_B:    pattern_b    <= wr_data[pcwa_pkg::PATTERN_W-1:0];
          pcwa_pkg::REG_CARRIER_BASE: carrier_base <= wr_data[pcwa_pkg::DUTY_W-1:0];
          default: begin
          end
        endcase
      end
      case (cmd.op)
        pcwa_pkg::OP_EVAL: begin
          if (match) begin
            idle_count <= '0;
            if (window_count < WCNT_W'(WINDOW_LIMIT)) begin
              window_sum    <= window_sum + WSUM_W'(diff);
              window_count  <= window_count + 1'b1;
              in_window     <= 1'b1;
              stopped_flag  <= 1'b0;
              stopped_count <= '0;
              kind          <= pcwa_pkg::KIND_FILL;
            end else begin
              window_sum   <= '0;
              window_count <= '0;
              burst_sum    <= '0;
              burst_count  <= '0;
              stopped_flag <= 1'b1;
              in_window    <= 1'b0;
              if (stopped_count < SCNT_W'(STOPPED_LIMIT)) begin
                stopped_sum   <= stopped_sum + SSUM_W'(diff);
                stopped_count <= stopped_count + 1'b1;
                kind          <= pcwa_pkg::KIND_STOP_ACC;
              end else begin
                kind <= pcwa_pkg::KIND_STOP_REPORT;
              end
            end
          end else if (in_window) begin
            in_window <= 1'b0;
            kind      <= pcwa_pkg::KIND_CLOSE;
          end else begin
            idle_count <= idle_next;
            kind       <= pcwa_pkg::KIND_IDLE;
          end
        end
        pcwa_pkg::OP_MEAN_START: begin
          // The divider has taken the window, so it can be cleared now.
          if (kind == pcwa_pkg::KIND_CLOSE) begin
            window_sum   <= '0;
            window_count <= '0;
          end
        end
        pcwa_pkg::OP_STOP_DONE: begin
          stopped_sum   <= '0;
          stopped_count <= '0;
        end
        pcwa_pkg::OP_BURST_ACC: begin
          burst_sum   <= burst_sum + BSUM_W'(div_quotient[VALUE_W-1:0]);
          burst_count <= burst_count + 1'b1;
        end
        pcwa_pkg::OP_BURST_DONE: begin
          burst_sum   <= '0;
          burst_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      pcwa_pkg::OP_LOAD: begin
        s_reg <= sample;
        p_reg <= pattern;
        d_reg <= duty;
      end
      pcwa_pkg::OP_EVAL: begin
        res_written <= !match && !in_window && (idle_next >= ICNT_W'(IDLE_LIMIT));
        res_value   <= '0;
      end
      pcwa_pkg::OP_MUL: begin
        prod <= PROD_W'(mean_q) * PROD_W'(d_reg);
      end
      pcwa_pkg::OP_STOP_DONE, pcwa_pkg::OP_BURST_DONE: begin
        res_written <= 1'b1;
        res_value   <= div_quotient[VALUE_W-1:0];
      end
      pcwa_pkg::OP_OUT_LOAD: begin
        result_written <= res_written;
        current_value  <= res_value;
        rotor_halted   <= stopped_flag;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.kind       = kind;
    status.div_done   = div_done;
    status.burst_full = (burst_count >= BCNT_W'(BURST_COUNT));
  end

endmodule

// File: design/pcwa_ctrl.sv
// ----------------------------------------------------------------------------
// pcwa_ctrl
// Sequencer that steps the datapath through one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "phase_current_window_averager_core_assert.svh"

module pcwa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pcwa_pkg::status_t status,
  output pcwa_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_DISPATCH,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_MUL,
    S_SCALE_GO,
    S_SCALE_WAIT,
    S_SCALE_DONE,
    S_BURST_CHK,
    S_BURST_GO,
    S_BURST_WAIT,
    S_BURST_DONE,
    S_EMIT
  } state_t;

  state_t state;
  logic   out_free;
  logic   report;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign report   = (status.kind == pcwa_pkg::KIND_STOP_REPORT);

  always_comb begin
    cmd.op = pcwa_pkg::OP_NONE;
    case (state)
      S_IDLE:       cmd.op = in_valid ? pcwa_pkg::OP_LOAD : pcwa_pkg::OP_NONE;
      S_EVAL:       cmd.op = pcwa_pkg::OP_EVAL;
      S_MEAN_GO:    cmd.op = pcwa_pkg::OP_MEAN_START;
      S_MUL:        cmd.op = pcwa_pkg::OP_MUL;
      S_SCALE_GO:   cmd.op = pcwa_pkg::OP_SCALE_START;
      S_SCALE_DONE: cmd.op = report ? pcwa_pkg::OP_STOP_DONE : pcwa_pkg::OP_BURST_ACC;
      S_BURST_GO:   cmd.op = pcwa_pkg::OP_BURST_START;
      S_BURST_DONE: cmd.op = pcwa_pkg::OP_BURST_DONE;
      S_EMIT:       cmd.op = out_free ? pcwa_pkg::OP_OUT_LOAD : pcwa_pkg::OP_NONE;
      default:      cmd.op = pcwa_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: state <= S_DISPATCH;
        S_DISPATCH: begin
          if (report || status.kind == pcwa_pkg::KIND_CLOSE) begin
            state <= S_MEAN_GO;
          end else begin
            state <= S_EMIT;
          end
        end
        S_MEAN_GO: state <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (status.div_done) begin
            state <= S_MUL;
          end
        end
        S_MUL:      state <= S_SCALE_GO;
        S_SCALE_GO: state <= S_SCALE_WAIT;
        S_SCALE_WAIT: begin
          if (status.div_done) begin
            state <= S_SCALE_DONE;
          end
        end
        S_SCALE_DONE: state <= report ? S_EMIT : S_BURST_CHK;
        S_BURST_CHK:  state <= status.burst_full ? S_BURST_GO : S_EMIT;
        S_BURST_GO:   state <= S_BURST_WAIT;
        S_BURST_WAIT: begin
          if (status.div_done) begin
            state <= S_BURST_DONE;
          end
        end
        S_BURST_DONE: state <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PCWA_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "word accepted while busy")
  `PCWA_ASSERT_NEXT(a_load_sets_valid, cmd.op == pcwa_pkg::OP_OUT_LOAD, out_valid, "result lost")
  `PCWA_ASSERT_IMP(a_no_overwrite, cmd.op == pcwa_pkg::OP_OUT_LOAD, out_free, "result overwritten")
  `PCWA_ASSERT_NEXT(a_start_clears_done,
                    cmd.op == pcwa_pkg::OP_MEAN_START || cmd.op == pcwa_pkg::OP_SCALE_START ||
                    cmd.op == pcwa_pkg::OP_BURST_START,
                    !status.div_done, "stale divider done")

endmodule
